FILE: hdl/pbmp_pkg.sv
// types, codes and a helper function shared by the method parser modules
package pbmp_pkg;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_INC    = 2'd1,
    MODE_FIXED  = 2'd2,
    MODE_ONCE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_BIND  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DROPPED     = 3'd1,
    ST_BAD_OPCODE  = 3'd2,
    ST_BAD_TERT    = 3'd3,
    ST_IMM_UNBOUND = 3'd4,
    ST_BAD_CLASS   = 3'd5,
    ST_HALTED      = 3'd6
  } status_t;

  localparam logic [2:0] OP_INC_LEGACY = 3'd0;
  localparam logic [2:0] OP_INC        = 3'd1;
  localparam logic [2:0] OP_FIXED      = 3'd3;
  localparam logic [2:0] OP_IMMEDIATE  = 3'd4;
  localparam logic [2:0] OP_ONCE       = 3'd5;

  localparam logic [31:0] CLASS_2D      = 32'h0000_902D;
  localparam logic [31:0] CLASS_INLINE  = 32'h0000_A140;
  localparam logic [31:0] CLASS_DMA     = 32'h0000_B0B5;
  localparam logic [31:0] CLASS_3D      = 32'h0000_B197;
  localparam logic [31:0] CLASS_COMPUTE = 32'h0000_B1C0;

  // bound code: 0 unbound, otherwise engine + 1
  localparam logic [2:0] CODE_UNBOUND = 3'd0;

  typedef struct packed {
    mode_t       mode;
    logic [12:0] remaining;
    logic [13:0] cur_method;
    logic [2:0]  cur_sub;
    logic        step_pending;
    logic        halted;
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  engine;
    logic [2:0]  sub;
    logic [13:0] method;
    logic [31:0] value;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [2:0] sub;
    logic [2:0] code;
  } bind_wr_t;

  function automatic logic [2:0] class_code(input logic [31:0] w);
    logic [2:0] code;
    code = CODE_UNBOUND;
    if (w == CLASS_2D)      code = 3'd1;
    if (w == CLASS_INLINE)  code = 3'd2;
    if (w == CLASS_DMA)     code = 3'd3;
    if (w == CLASS_3D)      code = 3'd4;
    if (w == CLASS_COMPUTE) code = 3'd5;
    return code;
  endfunction

endpackage

FILE: hdl/pbmp_bind_table.sv
// per-subchannel bound engine table with one read port and one write port
module pbmp_bind_table
  import pbmp_pkg::*;
#(
  parameter int SUBCHANNEL_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] rd_sub,
  output logic [2:0] rd_code,
  input  bind_wr_t   wr
);

  logic [2:0] entry [8];

  // entries at or above the subchannel count are never written and stay unbound
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        entry[i] <= CODE_UNBOUND;
      end
    end else if (wr.we && (int'(wr.sub) < SUBCHANNEL_COUNT)) begin
      entry[wr.sub] <= wr.code;
    end
  end

  assign rd_code = entry[rd_sub];

endmodule

FILE: hdl/pbmp_step.sv
// header decode and data word handling for one item
module pbmp_step
  import pbmp_pkg::*;
#(
  parameter int SUBCHANNEL_COUNT = 8
) (
  input  logic [31:0]  word,
  input  parse_state_t st,
  output logic [2:0]   rd_sub,
  input  logic [2:0]   rd_code,
  output parse_state_t st_next,
  output result_t      res,
  output bind_wr_t     bind_wr
);

  logic [11:0] hdr_addr;
  logic [2:0]  hdr_sub;
  logic [12:0] hdr_count;
  logic [2:0]  hdr_op;
  logic [2:0]  cls;
  logic [12:0] run_count;
  mode_t       run_mode;
  logic        run_start;
  logic [12:0] rem_dec;

  assign hdr_addr  = word[11:0];
  assign hdr_sub   = word[15:13];
  assign hdr_count = word[28:16];
  assign hdr_op    = word[31:29];
  assign cls       = class_code(word);
  assign rem_dec   = st.remaining - 13'd1;
  assign rd_sub    = (st.mode == MODE_HEADER) ? hdr_sub : st.cur_sub;

  always_comb begin
    st_next   = st;
    res       = '{kind: KIND_NONE, engine: 3'd0, sub: 3'd0, method: 14'd0,
                  value: 32'd0, status: ST_OK};
    bind_wr   = '{we: 1'b0, sub: st.cur_sub, code: cls};
    run_start = 1'b0;
    run_mode  = MODE_INC;
    run_count = hdr_count;

    if (st.halted) begin
      res.status = ST_HALTED;
    end else if (st.mode != MODE_HEADER) begin
      res.sub    = st.cur_sub;
      res.method = st.cur_method;
      res.value  = word;
      if (rd_code != CODE_UNBOUND) begin
        res.kind   = KIND_WRITE;
        res.engine = rd_code - 3'd1;
      end else if (st.cur_method != 14'd0) begin
        res.status = ST_DROPPED;
      end else if (cls != CODE_UNBOUND && (int'(st.cur_sub) < SUBCHANNEL_COUNT)) begin
        res.kind   = KIND_BIND;
        res.engine = cls - 3'd1;
        bind_wr.we = 1'b1;
      end else begin
        res.status     = ST_BAD_CLASS;
        st_next.halted = 1'b1;
      end
      if (st.mode == MODE_INC) begin
        st_next.cur_method = st.cur_method + 14'd1;
      end else if (st.mode == MODE_ONCE && st.step_pending) begin
        st_next.cur_method   = st.cur_method + 14'd1;
        st_next.step_pending = 1'b0;
      end
      st_next.remaining = rem_dec;
      if (rem_dec == 13'd0) begin
        st_next.mode         = MODE_HEADER;
        st_next.step_pending = 1'b0;
      end
    end else begin
      unique case (hdr_op)
        OP_INC_LEGACY: begin
          if (hdr_count[1:0] != 2'd0) begin
            res.status     = ST_BAD_TERT;
            st_next.halted = 1'b1;
          end else begin
            run_start = 1'b1;
            run_mode  = MODE_INC;
            run_count = {2'd0, hdr_count[12:2]};
          end
        end
        OP_INC: begin
          run_start = 1'b1;
          run_mode  = MODE_INC;
        end
        OP_FIXED: begin
          run_start = 1'b1;
          run_mode  = MODE_FIXED;
        end
        OP_ONCE: begin
          run_start = 1'b1;
          run_mode  = MODE_ONCE;
        end
        OP_IMMEDIATE: begin
          res.sub    = hdr_sub;
          res.method = {2'd0, hdr_addr};
          res.value  = {19'd0, hdr_count};
          if (rd_code == CODE_UNBOUND) begin
            res.status     = ST_IMM_UNBOUND;
            st_next.halted = 1'b1;
          end else begin
            res.kind   = KIND_WRITE;
            res.engine = rd_code - 3'd1;
          end
        end
        default: begin
          res.status     = ST_BAD_OPCODE;
          st_next.halted = 1'b1;
        end
      endcase
      if (run_start) begin
        st_next.cur_method   = {2'd0, hdr_addr};
        st_next.cur_sub      = hdr_sub;
        st_next.remaining    = run_count;
        st_next.step_pending = (run_mode == MODE_ONCE);
        st_next.mode         = (run_count != 13'd0) ? run_mode : MODE_HEADER;
      end
    end
  end

endmodule

FILE: hdl/gpu_push_buffer_method_parser.sv
// top level of the push buffer method parser: input and result registers
// usage:
//   input channel: one 32-bit command list word per item on word, taken when
//   in_valid is high and in_stall is low; headers and data words share it
//   result channel: exactly one result item per input item, presented on
//   kind, engine, subchannel_out, method, value and status with out_valid,
//   taken when out_stall is low
//   path: an accepted item is captured in the input register, and its result
//   moves into the result register, where out_valid marks it, once that register
//   is free or its result is being taken
//   throughput: one item per cycle while out_stall is low; decode and the
//   bind table lookup sit in the single stage between the two registers
//   stall: while out_stall holds a result, one further item waits in the
//   input register; in_stall rises only when both registers are full
//   reset: rst clears the parse state, the halt flag and every subchannel
//   binding at once; the block takes items in the first cycle after reset
//   after a fatal condition every result reports halted until the next reset
module gpu_push_buffer_method_parser
  import pbmp_pkg::*;
#(
  parameter int SUBCHANNEL_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  engine,
  output logic [2:0]  subchannel_out,
  output logic [13:0] method,
  output logic [31:0] value,
  output logic [2:0]  status
);

  logic         s1_valid;
  logic [31:0]  s1_word;
  logic         s1_move;
  parse_state_t st;
  parse_state_t st_next;
  result_t      res;
  result_t      out_res;
  bind_wr_t     bind_wr;
  bind_wr_t     bind_wr_gated;
  logic [2:0]   rd_sub;
  logic [2:0]   rd_code;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  pbmp_step #(
    .SUBCHANNEL_COUNT (SUBCHANNEL_COUNT)
  ) u_step (
    .word    (s1_word),
    .st      (st),
    .rd_sub  (rd_sub),
    .rd_code (rd_code),
    .st_next (st_next),
    .res     (res),
    .bind_wr (bind_wr)
  );

  assign bind_wr_gated = '{we: bind_wr.we && s1_move, sub: bind_wr.sub, code: bind_wr.code};

  pbmp_bind_table #(
    .SUBCHANNEL_COUNT (SUBCHANNEL_COUNT)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_sub  (rd_sub),
    .rd_code (rd_code),
    .wr      (bind_wr_gated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: MODE_HEADER, remaining: 13'd0, cur_method: 14'd0, cur_sub: 3'd0,
              step_pending: 1'b0, halted: 1'b0};
    end else if (s1_move) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res <= res;
    end
  end

  assign kind           = out_res.kind;
  assign engine         = out_res.engine;
  assign subchannel_out = out_res.sub;
  assign method         = out_res.method;
  assign value          = out_res.value;
  assign status         = out_res.status;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    st.halted |=> st.halted)
    else $error("halt flag cleared without reset");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (st.mode != MODE_HEADER) |-> (st.remaining != 13'd0))
    else $error("method run active with no words remaining");

  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == ST_HALTED) |-> (out_res.kind == KIND_NONE))
    else $error("halted result issued a write or bind");

  a_bind_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == KIND_BIND) |->
      (out_res.status == ST_OK && out_res.method == 14'd0))
    else $error("bind result with bad status or method");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled while a register is free");
`endif

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the push buffer method parser
module testbench;
  import pbmp_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 600;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [2:0] KEEP_FREE = 3'd6;  // subchannel left unbound until the end
  localparam logic [2:0] OP_RSVD2 = 3'd2;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [2:0]  engine;
  logic [2:0]  subchannel_out;
  logic [13:0] method;
  logic [31:0] value;
  logic [2:0]  status;

  gpu_push_buffer_method_parser u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .word(word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .engine(engine),
    .subchannel_out(subchannel_out),
    .method(method),
    .value(value),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser state as predicted
  mode_t       run_mode = MODE_HEADER;
  logic [12:0] run_left = '0;
  logic [13:0] run_addr = '0;
  logic [2:0]  run_sub = '0;
  logic        run_step = 1'b0;
  logic        stopped = 1'b0;
  logic [2:0]  sub_bind [8];

  typedef struct {
    logic [31:0] w;
    bit          typed;
    result_t     want;
  } stim_row_t;

  stim_row_t steps [$];
  result_t   pending_results [$];

  int burst_left = 0;
  int n_words = 0;
  int n_mismatch = 0;
  int n_writes = 0;
  int n_binds = 0;
  int n_drops = 0;
  int n_halted = 0;
  int idle_cycles = 0;
  int fatal_pick;
  logic [31:0] stall_bits = '0;
  int stall_left = 0;

  function automatic logic [31:0] hdr(input logic [2:0] op, input logic [2:0] sb,
                                      input logic [12:0] cnt, input logic [11:0] addr);
    return {op, cnt, sb, 1'b0, addr};
  endfunction

  function automatic result_t mk_res(input kind_t k, input logic [2:0] e,
                                     input logic [2:0] s, input logic [13:0] m,
                                     input logic [31:0] v, input status_t st);
    result_t r;
    r.kind = k;
    r.engine = e;
    r.sub = s;
    r.method = m;
    r.value = v;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] class_id(input int idx);
    case (idx)
      0: return CLASS_2D;
      1: return CLASS_INLINE;
      2: return CLASS_DMA;
      3: return CLASS_3D;
      default: return CLASS_COMPUTE;
    endcase
  endfunction

  // engine + 1 for a known class, zero otherwise
  function automatic logic [2:0] class_slot(input logic [31:0] w);
    case (w)
      CLASS_2D: return 3'd1;
      CLASS_INLINE: return 3'd2;
      CLASS_DMA: return 3'd3;
      CLASS_3D: return 3'd4;
      CLASS_COMPUTE: return 3'd5;
      default: return CODE_UNBOUND;
    endcase
  endfunction

  function automatic void start_run(input mode_t m, input logic [11:0] addr,
                                    input logic [2:0] sb, input logic [12:0] n);
    run_addr = {2'b00, addr};
    run_sub = sb;
    run_left = n;
    run_step = (m == MODE_ONCE);
    run_mode = (n != '0) ? m : MODE_HEADER;
  endfunction

  function automatic result_t parse_word(input logic [31:0] w);
    result_t r;
    logic [2:0] op, sb, slot;
    logic [12:0] cnt;
    r = '0;
    if (stopped) begin
      r.status = ST_HALTED;
      return r;
    end
    if (run_mode != MODE_HEADER) begin
      r.sub = run_sub;
      r.method = run_addr;
      r.value = w;
      if (sub_bind[run_sub] != CODE_UNBOUND) begin
        r.kind = KIND_WRITE;
        r.engine = sub_bind[run_sub] - 3'd1;
      end else if (run_addr != '0) begin
        r.status = ST_DROPPED;
      end else begin
        slot = class_slot(w);
        if (slot != CODE_UNBOUND) begin
          sub_bind[run_sub] = slot;
          r.kind = KIND_BIND;
          r.engine = slot - 3'd1;
        end else begin
          stopped = 1'b1;
          r.status = ST_BAD_CLASS;
        end
      end
      if (run_mode == MODE_INC) begin
        run_addr = run_addr + 14'd1;
      end else if (run_mode == MODE_ONCE && run_step) begin
        run_addr = run_addr + 14'd1;
        run_step = 1'b0;
      end
      run_left = run_left - 13'd1;
      if (run_left == '0) begin
        run_mode = MODE_HEADER;
        run_step = 1'b0;
      end
      return r;
    end
    op = w[31:29];
    cnt = w[28:16];
    sb = w[15:13];
    case (op)
      OP_INC_LEGACY: begin
        if (cnt[1:0] != 2'b00) begin
          stopped = 1'b1;
          r.status = ST_BAD_TERT;
        end else begin
          start_run(MODE_INC, w[11:0], sb, {2'b00, cnt[12:2]});
        end
      end
      OP_INC: start_run(MODE_INC, w[11:0], sb, cnt);
      OP_FIXED: start_run(MODE_FIXED, w[11:0], sb, cnt);
      OP_ONCE: start_run(MODE_ONCE, w[11:0], sb, cnt);
      OP_IMMEDIATE: begin
        r.sub = sb;
        r.method = {2'b00, w[11:0]};
        r.value = {19'b0, cnt};
        if (sub_bind[sb] != CODE_UNBOUND) begin
          r.kind = KIND_WRITE;
          r.engine = sub_bind[sb] - 3'd1;
        end else begin
          stopped = 1'b1;
          r.status = ST_IMM_UNBOUND;
        end
      end
      default: begin
        stopped = 1'b1;
        r.status = ST_BAD_OPCODE;
      end
    endcase
    return r;
  endfunction

  // headers that never halt the parser
  function automatic logic [31:0] rand_header();
    logic [2:0] op, sb;
    logic [11:0] addr;
    logic [12:0] cnt;
    int n;
    sb = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: addr = '0;
      1: addr = 12'hFFF - 12'($urandom_range(0, 3));
      default: addr = 12'($urandom);
    endcase
    if (sb == KEEP_FREE && addr == '0) addr = 12'($urandom_range(1, 4095));
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    cnt = 13'(n);
    case ($urandom_range(0, 4))
      0: begin
        op = OP_INC_LEGACY;
        cnt = 13'(n << 2);
      end
      1: op = OP_INC;
      2: op = OP_FIXED;
      3: op = OP_ONCE;
      default: begin
        op = OP_IMMEDIATE;
        cnt = 13'($urandom);
      end
    endcase
    if (op == OP_IMMEDIATE && sub_bind[sb] == CODE_UNBOUND) begin
      op = OP_FIXED;
      cnt = 13'(n);
    end
    return {op, cnt, sb, 1'($urandom), addr};
  endfunction

  function automatic logic [31:0] rand_data();
    if (sub_bind[run_sub] == CODE_UNBOUND && run_addr == '0)
      return class_id($urandom_range(0, 4));
    case ($urandom_range(0, 7))
      0: return class_id($urandom_range(0, 4));
      1: return '0;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [31:0] w, input bit typed, input result_t want);
    result_t guess;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = parse_word(w);
    pending_results.push_back(typed ? want : guess);
    n_words++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_bits = '0;
        1: stall_bits = $urandom;
        2: stall_bits = $urandom & $urandom;
        default: stall_bits = $urandom | $urandom;
      endcase
      stall_left = 32;
    end
    out_stall <= stall_bits[0];
    stall_bits = stall_bits >> 1;
    stall_left--;
  end

  // result checking
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= SHOWN_MISMATCHES)
          $display("unexpected result item: kind %0d status %0d", kind, status);
      end else begin
        want = pending_results.pop_front();
        case (want.kind)
          KIND_WRITE: n_writes++;
          KIND_BIND: n_binds++;
          default: ;
        endcase
        if (want.status == ST_DROPPED) n_drops++;
        if (want.status == ST_HALTED) n_halted++;
        if (kind !== want.kind || engine !== want.engine || subchannel_out !== want.sub ||
            method !== want.method || value !== want.value || status !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= SHOWN_MISMATCHES) begin
            $display("mismatch: want kind %0d eng %0d sub %0d meth %h val %h st %0d",
                     want.kind, want.engine, want.sub, want.method, want.value,
                     want.status);
            $display("          got  kind %0d eng %0d sub %0d meth %h val %h st %0d",
                     kind, engine, subchannel_out, method, value, status);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    result_t hz;
    stim_row_t r;
    logic [31:0] w;
    logic [2:0] op;
    foreach (sub_bind[i]) sub_bind[i] = CODE_UNBOUND;
    hz = mk_res(KIND_NONE, 3'd0, 3'd0, 14'd0, 32'd0, ST_OK);

    // directed table: word, typed flag, typed result
    r.typed = 1'b1;
    r.w = hdr(OP_INC, 3'd0, 13'd2, 12'h000);  r.want = hz;  steps.push_back(r);
    r.w = CLASS_3D;
    r.want = mk_res(KIND_BIND, 3'd3, 3'd0, 14'd0, CLASS_3D, ST_OK);  steps.push_back(r);
    r.w = 32'hFFFF_FFFF;
    r.want = mk_res(KIND_WRITE, 3'd3, 3'd0, 14'd1, 32'hFFFF_FFFF, ST_OK);  steps.push_back(r);
    r.w = hdr(OP_ONCE, 3'd1, 13'd3, 12'h000);  r.want = hz;  steps.push_back(r);
    r.w = CLASS_2D;
    r.want = mk_res(KIND_BIND, 3'd0, 3'd1, 14'd0, CLASS_2D, ST_OK);  steps.push_back(r);
    r.w = 32'h0;
    r.want = mk_res(KIND_WRITE, 3'd0, 3'd1, 14'd1, 32'h0, ST_OK);  steps.push_back(r);
    r.typed = 1'b0;
    r.w = 32'h1234_5678;  steps.push_back(r);
    r.typed = 1'b1;
    r.w = hdr(OP_FIXED, 3'd2, 13'd2, 12'hFFF);  r.want = hz;  steps.push_back(r);
    r.w = 32'h5A5A_A5A5;
    r.want = mk_res(KIND_NONE, 3'd0, 3'd2, 14'h0FFF, 32'h5A5A_A5A5, ST_DROPPED);
    steps.push_back(r);
    r.typed = 1'b0;
    r.w = CLASS_DMA;  steps.push_back(r);
    r.typed = 1'b1;
    r.w = hdr(OP_INC_LEGACY, 3'd0, 13'd8, 12'h7FF);  r.want = hz;  steps.push_back(r);
    r.typed = 1'b0;
    r.w = 32'hDEAD_BEEF;  steps.push_back(r);
    r.w = 32'h8000_0001;  steps.push_back(r);
    r.typed = 1'b1;
    r.w = hdr(OP_INC, 3'd5, 13'd0, 12'h123);  r.want = hz;  steps.push_back(r);
    r.w = 32'h0;  r.want = hz;  steps.push_back(r);
    r.w = hdr(OP_IMMEDIATE, 3'd0, 13'h1FFF, 12'hFFF);
    r.want = mk_res(KIND_WRITE, 3'd3, 3'd0, 14'h0FFF, 32'h1FFF, ST_OK);  steps.push_back(r);
    r.w = hdr(OP_IMMEDIATE, 3'd1, 13'd0, 12'h000);
    r.want = mk_res(KIND_WRITE, 3'd0, 3'd1, 14'd0, 32'd0, ST_OK);  steps.push_back(r);
    r.w = hdr(OP_INC, 3'd3, 13'd3, 12'h000);  r.want = hz;  steps.push_back(r);
    r.w = CLASS_DMA;
    r.want = mk_res(KIND_BIND, 3'd2, 3'd3, 14'd0, CLASS_DMA, ST_OK);  steps.push_back(r);
    r.w = CLASS_INLINE;
    r.want = mk_res(KIND_WRITE, 3'd2, 3'd3, 14'd1, CLASS_INLINE, ST_OK);  steps.push_back(r);
    r.typed = 1'b0;
    r.w = 32'h7FFF_FFFE;  steps.push_back(r);
    r.typed = 1'b1;
    r.w = hdr(OP_ONCE, 3'd4, 13'd1, 12'h000);  r.want = hz;  steps.push_back(r);
    r.w = CLASS_COMPUTE;
    r.want = mk_res(KIND_BIND, 3'd4, 3'd4, 14'd0, CLASS_COMPUTE, ST_OK);  steps.push_back(r);
    r.w = hdr(OP_FIXED, 3'd7, 13'd1, 12'h000);  r.want = hz;  steps.push_back(r);
    r.w = CLASS_INLINE;
    r.want = mk_res(KIND_BIND, 3'd1, 3'd7, 14'd0, CLASS_INLINE, ST_OK);  steps.push_back(r);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) send_word(steps[i].w, steps[i].typed, steps[i].want);
    drain();

    // run with the method address crossing into the upper bits
    send_word(hdr(OP_INC, 3'd0, 13'd6, 12'hFFF), 1'b1, hz);
    while (run_mode != MODE_HEADER) send_word($urandom, 1'b0, hz);
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain();
      if (run_mode == MODE_HEADER) send_word(rand_header(), 1'b0, hz);
      else send_word(rand_data(), 1'b0, hz);
    end
    while (run_mode != MODE_HEADER) send_word(rand_data(), 1'b0, hz);

    // one fatal case per run, then the halted state
    fatal_pick = $urandom_range(0, 3);
    w = $urandom;
    case (fatal_pick)
      0: begin
        case ($urandom_range(0, 2))
          0: op = OP_RSVD2;
          1: op = OP_RSVD6;
          default: op = OP_RSVD7;
        endcase
        w[31:29] = op;
        send_word(w, 1'b1, mk_res(KIND_NONE, 3'd0, 3'd0, 14'd0, 32'd0, ST_BAD_OPCODE));
      end
      1: begin
        w[31:29] = OP_INC_LEGACY;
        w[17:16] = 2'($urandom_range(1, 3));
        send_word(w, 1'b1, mk_res(KIND_NONE, 3'd0, 3'd0, 14'd0, 32'd0, ST_BAD_TERT));
      end
      2: begin
        w[31:29] = OP_IMMEDIATE;
        w[15:13] = KEEP_FREE;
        send_word(w, 1'b1, mk_res(KIND_NONE, 3'd0, KEEP_FREE, {2'b00, w[11:0]},
                                  {19'b0, w[28:16]}, ST_IMM_UNBOUND));
      end
      default: begin
        send_word(hdr(OP_FIXED, KEEP_FREE, 13'd2, 12'h000), 1'b1, hz);
        w = class_id($urandom_range(0, 4)) ^ (32'h1 << $urandom_range(0, 31));
        send_word(w, 1'b1, mk_res(KIND_NONE, 3'd0, KEEP_FREE, 14'd0, w, ST_BAD_CLASS));
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      w = (i == 0) ? 32'hFFFF_FFFF : $urandom;
      send_word(w, 1'b1, mk_res(KIND_NONE, 3'd0, 3'd0, 14'd0, 32'd0, ST_HALTED));
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d words: %0d method writes, %0d binds, %0d dropped data words",
             n_words, n_writes, n_binds, n_drops);
    $display("closing fatal case %0d, then %0d halted results", fatal_pick, n_halted);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
